[hdl/straw_tube_channel_mapper_defines.svh]
// Assertion macros used by the straw-tube channel mapper RTL.
`ifndef STRAW_TUBE_CHANNEL_MAPPER_DEFINES_SVH
`define STRAW_TUBE_CHANNEL_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STCM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/stcm_pkg.sv]
// Types, widths and geometry constants of the straw-tube channel mapper.
package stcm_pkg;

   localparam int TUBE_W     = 12;
   localparam int LAYER_W    = 6;
   localparam int GT_W       = 14;
   localparam int HOLE_W     = 10;
   localparam int DIVIDEND_W = 13;
   localparam int DIVISOR_W  = 9;
   localparam int QUOT_W     = 6;
   localparam int IN_DATA_W  = 24;
   localparam int OUT_DATA_W = 24;

   localparam logic [2:0] CHAMBER_1 = 3'd1;
   localparam logic [2:0] CHAMBER_2 = 3'd2;
   localparam logic [2:0] CHAMBER_3 = 3'd3;
   localparam logic [2:0] CHAMBER_4 = 3'd4;
   localparam logic [2:0] CHAMBER_5 = 3'd5;
   localparam logic [2:0] CHAMBER_6 = 3'd6;

   localparam logic [1:0] KIND_FULL = 2'd0;
   localparam logic [1:0] KIND_UP   = 2'd1;
   localparam logic [1:0] KIND_DOWN = 2'd2;
   localparam logic [1:0] KIND_ALT  = 2'd3;

   localparam logic [DIVISOR_W-1:0] TUBES_CH12 = 9'd132;
   localparam logic [DIVISOR_W-1:0] TUBES_CH3  = 9'd176;
   localparam logic [DIVISOR_W-1:0] TUBES_CH4  = 9'd208;
   localparam logic [DIVISOR_W-1:0] TUBES_CH56 = 9'd388;

   localparam logic [DIVIDEND_W-1:0] QUARTER_CH3 = 13'd352;
   localparam logic [DIVIDEND_W-1:0] QUARTER_CH4 = 13'd416;

   localparam logic [DIVISOR_W-1:0] HOLE_CH12     = 9'd61;
   localparam logic [DIVISOR_W-1:0] HOLE_CH3      = 9'd81;
   localparam logic [DIVISOR_W-1:0] HOLE_CH4_LOW  = 9'd97;
   localparam logic [DIVISOR_W-1:0] HOLE_CH4      = 9'd103;
   localparam logic [DIVISOR_W-1:0] HOLE_CH56_LOW = 9'd177;
   localparam logic [DIVISOR_W-1:0] HOLE_CH56     = 9'd194;

   // Global numbering offsets of each chamber.
   localparam logic [GT_W-1:0] OFFSET_CH2 = 14'd1152;
   localparam logic [GT_W-1:0] OFFSET_CH3 = 14'd2112;
   localparam logic [GT_W-1:0] OFFSET_CH4 = 14'd3520;
   localparam logic [GT_W-1:0] OFFSET_CH5 = 14'd5632;
   localparam logic [GT_W-1:0] OFFSET_CH6 = 14'd8928;
   localparam logic [GT_W-1:0] SHIFT_CH3  = 14'd192;
   localparam logic [GT_W-1:0] SHIFT_CH4  = 14'd320;
   localparam logic [GT_W-1:0] PAIR_CH3   = 14'd384;
   localparam logic [GT_W-1:0] PAIR_CH4   = 14'd448;

   typedef struct packed {
      logic busy;
      logic done;
   } stcm_div_status_type;

   function automatic logic [DIVISOR_W-1:0] tubes_per_layer(input logic [2:0] chamber);
      logic [DIVISOR_W-1:0] per;
      unique case (chamber)
         CHAMBER_3: per = TUBES_CH3;
         CHAMBER_4: per = TUBES_CH4;
         CHAMBER_5, CHAMBER_6: per = TUBES_CH56;
         default: per = TUBES_CH12;
      endcase
      return per;
   endfunction

endpackage

[hdl/stcm_divider.sv]
// Divider by repeated subtraction: one compare-subtract step per cycle.
module stcm_divider import stcm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output stcm_div_status_type   status,
   output logic [QUOT_W-1:0]     quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W:0]   diff;

   assign diff = (DIVIDEND_W+1)'(rem_ff) - (DIVIDEND_W+1)'(divisor_ff);

   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = dividend;
         quot_in    = '0;
         divisor_in = divisor;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         // A borrow means the remainder is already below the divisor.
         if (!diff[DIVIDEND_W]) begin
            rem_in  = diff[DIVIDEND_W-1:0];
            quot_in = quot_ff + QUOT_W'(1);
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;
   assign remainder   = rem_ff[DIVISOR_W-1:0];

endmodule

[hdl/straw_tube_channel_mapper.sv]
// Straw-tube channel mapper top level: hit in, layer, global tube and skew out.
// A hit passes from its transfer through the divide state and the output state to the
// result register; the divider counts the whole layers below the tube (0 to 31), one
// subtraction per cycle. A new hit is taken in the cycle after the result is loaded.
// The result register frees the divider while a finished result waits to be taken.
// Synchronous active-high reset empties the result register and returns to idle.
`include "straw_tube_channel_mapper_defines.svh"

module straw_tube_channel_mapper import stcm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // chamber [2:0], local_tube [14:3], module_quarter [16:15], half_tube [18:17], zeros
   input  logic [IN_DATA_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // layer [5:0], global_tube [19:6], skew [21:20], zeros
   output logic [OUT_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]        chamber_ff;
   logic [TUBE_W-1:0] tube_ff;
   logic [1:0]        kind_ff;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_DATA_W-1:0] rsp_tdata_ff;

   logic                  div_start;
   logic                  load_out;
   logic [2:0]            in_chamber;
   logic [TUBE_W-1:0]     in_tube;
   logic [1:0]            in_quarter;
   logic [1:0]            in_kind;
   logic [DIVIDEND_W-1:0] quarter_off;
   logic [DIVIDEND_W-1:0] tube_sum;
   logic [DIVIDEND_W-1:0] dividend;
   stcm_div_status_type   div_status;
   logic [QUOT_W-1:0]     div_quot;
   logic [DIVISOR_W-1:0]  div_rem;

   // Result datapath
   logic [LAYER_W-1:0]   layer_first, layer_w;
   logic [DIVISOR_W-1:0] per_c, low_c, near_c;
   logic [HOLE_W-1:0]    gap_c, gap_lo, gap_hi, hole_flat, hole_pair, pair_base;
   logic [HOLE_W-1:0]    flat_dist;
   logic [DIVIDEND_W-1:0] pair_tgt;
   logic [DIVIDEND_W:0]  pair_diff;
   logic [DIVIDEND_W-1:0] pair_dist;
   logic                 odd;
   logic [GT_W-1:0]      gt_w, tube_ext, pair_term;
   logic [1:0]           skew_w;

   assign in_chamber = req_tdata[2:0];
   assign in_tube    = req_tdata[14:3];
   assign in_quarter = req_tdata[16:15];
   assign in_kind    = (req_tdata[18:17] == KIND_ALT) ? KIND_FULL : req_tdata[18:17];

   // Chambers 3 and 4 count the sub-module quarter as two layers of tubes each.
   always_comb begin
      unique case (in_chamber)
         CHAMBER_3: quarter_off = DIVIDEND_W'(in_quarter) * QUARTER_CH3;
         CHAMBER_4: quarter_off = DIVIDEND_W'(in_quarter) * QUARTER_CH4;
         default:   quarter_off = '0;
      endcase
      tube_sum = DIVIDEND_W'(in_tube) + quarter_off;
      // Tube zero lies in the first layer, like tube one.
      dividend = (tube_sum == '0) ? '0 : tube_sum - DIVIDEND_W'(1);
   end

   stcm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (tubes_per_layer(in_chamber)),
      .status    (div_status),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load_out) rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
   end

   // Per-chamber geometry of the finished hit.
   always_comb begin
      per_c       = tubes_per_layer(chamber_ff);
      layer_first = LAYER_W'(1);
      low_c       = HOLE_CH12;
      near_c      = HOLE_CH12;
      gap_c       = HOLE_W'(12);
      unique case (chamber_ff)
         CHAMBER_1: layer_first = LAYER_W'(1);
         CHAMBER_2: layer_first = LAYER_W'(9);
         CHAMBER_3: begin
            layer_first = LAYER_W'(17);
            low_c       = HOLE_CH3;
            near_c      = HOLE_CH3;
         end
         CHAMBER_4: begin
            layer_first = LAYER_W'(25);
            low_c       = HOLE_CH4_LOW;
            near_c      = HOLE_CH4;
         end
         CHAMBER_5: begin
            layer_first = LAYER_W'(33);
            low_c       = HOLE_CH56_LOW;
            near_c      = HOLE_CH56;
            gap_c       = HOLE_W'(24);
         end
         CHAMBER_6: begin
            layer_first = LAYER_W'(41);
            low_c       = HOLE_CH56_LOW;
            near_c      = HOLE_CH56;
            gap_c       = HOLE_W'(24);
         end
         default: layer_first = LAYER_W'(1);
      endcase

      layer_w = layer_first + LAYER_W'(div_quot);
      odd     = layer_w[0];

      gap_lo = gap_c * HOLE_W'(div_quot);
      gap_hi = gap_lo + gap_c;

      // The remainder places the tube against the top of its layer.
      flat_dist = HOLE_W'(per_c) - HOLE_W'(1) - HOLE_W'(div_rem);
      if (kind_ff == KIND_UP) hole_flat = gap_lo;
      else if (kind_ff == KIND_DOWN) hole_flat = gap_hi;
      else if (tube_ff <= TUBE_W'(low_c)) hole_flat = '0;
      else if (flat_dist <= HOLE_W'(near_c)) hole_flat = gap_hi;
      else hole_flat = gap_lo;

      pair_tgt  = odd ? DIVIDEND_W'(per_c) : DIVIDEND_W'(per_c) << 1;
      pair_diff = (DIVIDEND_W+1)'(tube_ff) - (DIVIDEND_W+1)'(pair_tgt);
      pair_dist = pair_diff[DIVIDEND_W] ? DIVIDEND_W'(-pair_diff) : pair_diff[DIVIDEND_W-1:0];
      pair_base = odd ? HOLE_W'(0) : HOLE_W'(16);
      if (kind_ff == KIND_UP) hole_pair = pair_base;
      else if (kind_ff == KIND_DOWN) hole_pair = pair_base + HOLE_W'(16);
      else if (tube_ff <= TUBE_W'(low_c)) hole_pair = '0;
      else if (pair_dist <= DIVIDEND_W'(near_c)) hole_pair = pair_base + HOLE_W'(16);
      else hole_pair = pair_base;

      tube_ext = GT_W'(tube_ff);
      unique case (chamber_ff)
         CHAMBER_3: pair_term = GT_W'(div_quot[2:1]) * PAIR_CH3;
         CHAMBER_4: pair_term = GT_W'(div_quot[2:1]) * PAIR_CH4;
         default:   pair_term = '0;
      endcase

      unique case (chamber_ff)
         CHAMBER_1: gt_w = tube_ext + GT_W'(hole_flat);
         CHAMBER_2: gt_w = tube_ext + OFFSET_CH2 + GT_W'(hole_flat);
         CHAMBER_3: begin
            // Past the fourth layer pair only the shifts remain.
            gt_w = (div_quot <= QUOT_W'(7)) ? tube_ext + OFFSET_CH3 + pair_term : '0;
            gt_w = gt_w + SHIFT_CH3 + GT_W'(hole_pair);
         end
         CHAMBER_4: begin
            gt_w = (div_quot <= QUOT_W'(7)) ? tube_ext + OFFSET_CH4 + pair_term : '0;
            gt_w = gt_w + SHIFT_CH4 + GT_W'(hole_pair);
         end
         CHAMBER_5: gt_w = tube_ext + OFFSET_CH5 + GT_W'(hole_flat);
         CHAMBER_6: gt_w = tube_ext + OFFSET_CH6 + GT_W'(hole_flat);
         default:   gt_w = '0;
      endcase

      if (chamber_ff == 3'd0 || chamber_ff == 3'd7) layer_w = LAYER_W'(1);

      skew_w = 2'b00;
      if (layer_w <= LAYER_W'(46)) begin
         if (layer_w[2:0] == 3'd3 || layer_w[2:0] == 3'd4) skew_w = 2'b01;
         else if (layer_w[2:0] == 3'd5 || layer_w[2:0] == 3'd6) skew_w = 2'b11;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         chamber_ff <= in_chamber;
         tube_ff    <= in_tube;
         kind_ff    <= in_kind;
      end
      if (load_out) begin
         rsp_tdata_ff <= {2'b00, skew_w, gt_w, layer_w};
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `STCM_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_tvalid && req_tready, state_ff == ST_DIV && div_status.busy, "accepted hit did not start the divider")
   `STCM_ASSERT_IMPLY(a_done_in_div, clock, reset, div_status.done, state_ff == ST_DIV, "divider finished outside the divide state")
   `STCM_ASSERT_IMPLY(a_ready_not_busy, clock, reset, req_tready, !div_status.busy, "ready while the divider is busy")
   `STCM_ASSERT_IMPLY(a_load_from_out, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == ST_OUT, "result loaded outside the output state")
   `STCM_ASSERT_IMPLY(a_quot_range, clock, reset, state_ff == ST_OUT, div_quot <= QUOT_W'(40), "layer count out of range")

endmodule

[sim/tb.sv]
// Self-checking testbench for the straw-tube channel mapper stream block.
`timescale 1ns / 100ps

module tb;
   import stcm_pkg::*;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int MAX_PRINTED    = 100;

   // Geometry as plain integers so the mapping arithmetic stays signed.
   localparam int PER_CH12      = int'(TUBES_CH12);
   localparam int PER_CH3       = int'(TUBES_CH3);
   localparam int PER_CH4       = int'(TUBES_CH4);
   localparam int PER_CH56      = int'(TUBES_CH56);
   localparam int STEP_CH3      = int'(QUARTER_CH3);
   localparam int STEP_CH4      = int'(QUARTER_CH4);
   localparam int NEAR_CH12     = int'(HOLE_CH12);
   localparam int NEAR_CH3      = int'(HOLE_CH3);
   localparam int NEAR_CH4_LOW  = int'(HOLE_CH4_LOW);
   localparam int NEAR_CH4      = int'(HOLE_CH4);
   localparam int NEAR_CH56_LOW = int'(HOLE_CH56_LOW);
   localparam int NEAR_CH56     = int'(HOLE_CH56);

   typedef struct {
      logic [5:0]  layer;
      logic [13:0] global_tube;
      logic [1:0]  skew;
      logic [18:0] hit;
   } tube_map_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // chamber [2:0], local_tube [14:3], module_quarter [16:15], half_tube [18:17], zeros
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // layer [5:0], global_tube [19:6], skew [21:20], zeros
   logic [OUT_DATA_W-1:0] rsp_tdata;

   tube_map_type pending_maps[$];
   tube_map_type want;
   int        mismatch_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        holdoff_ticket = 0;
   int        holdoff_seen = 0;
   int        holdoff_left = 0;

   straw_tube_channel_mapper DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- mapping

   function automatic int layer_from(input int first, input int tube, input int per);
      if (tube <= 0)
         return first;
      return first + (tube - 1) / per;
   endfunction

   // Hole shift of the flat chambers; lay counts layers within the chamber from one.
   function automatic int hole_flat_shift(input int kind, input int t, input int lay,
                                          input int per, input int low, input int near,
                                          input int gap);
      int d;
      if (kind == int'(KIND_UP))
         return gap * (lay - 1);
      if (kind == int'(KIND_DOWN))
         return gap * lay;
      if (t <= low)
         return 0;
      d = t - per * lay;
      if (d < 0)
         d = -d;
      return (d <= near) ? gap * lay : gap * (lay - 1);
   endfunction

   function automatic int hole_pair_shift(input int kind, input int t, input int odd,
                                          input int per, input int low, input int near);
      int base;
      int d;
      base = odd ? 0 : 16;
      if (kind == int'(KIND_UP))
         return base;
      if (kind == int'(KIND_DOWN))
         return base + 16;
      if (t <= low)
         return 0;
      d = t - (odd ? per : 2 * per);
      if (d < 0)
         d = -d;
      return (d <= near) ? base + 16 : base;
   endfunction

   function automatic tube_map_type map_hit(input logic [18:0] hit);
      tube_map_type r;
      logic [2:0]  chamber;
      int          t;
      int          q;
      int          kind;
      int          lay;
      int          gt;
      int          sk;
      int          m;
      chamber = hit[2:0];
      t = int'(hit[14:3]);
      q = int'(hit[16:15]);
      kind = int'(hit[18:17]);
      if (kind == int'(KIND_ALT))
         kind = int'(KIND_FULL);
      lay = 1;
      gt = 0;
      sk = 0;
      case (chamber)
         CHAMBER_1: begin
            lay = layer_from(1, t, PER_CH12);
            gt = t + hole_flat_shift(kind, t, lay, PER_CH12, NEAR_CH12, NEAR_CH12, 12);
         end
         CHAMBER_2: begin
            lay = layer_from(9, t, PER_CH12);
            gt = t + 8 * PER_CH12 + 96 +
                 hole_flat_shift(kind, t, lay - 8, PER_CH12, NEAR_CH12, NEAR_CH12, 12);
         end
         CHAMBER_3: begin
            lay = layer_from(17, t + q * STEP_CH3, PER_CH3);
            if (lay <= 24)
               gt = t + 16 * PER_CH12 + ((lay - 17) / 2) * (2 * PER_CH3 + 32);
            gt += 192 + hole_pair_shift(kind, t, lay & 1, PER_CH3, NEAR_CH3, NEAR_CH3);
         end
         CHAMBER_4: begin
            lay = layer_from(25, t + q * STEP_CH4, PER_CH4);
            if (lay <= 32)
               gt = t + 16 * PER_CH12 + 8 * PER_CH3 + ((lay - 25) / 2) * (2 * PER_CH4 + 32);
            gt += 320 + hole_pair_shift(kind, t, lay & 1, PER_CH4, NEAR_CH4_LOW, NEAR_CH4);
         end
         CHAMBER_5: begin
            lay = layer_from(33, t, PER_CH56);
            gt = t + 16 * PER_CH12 + 8 * PER_CH3 + 8 * PER_CH4 + 448 +
                 hole_flat_shift(kind, t, lay - 32, PER_CH56, NEAR_CH56_LOW, NEAR_CH56, 24);
         end
         CHAMBER_6: begin
            lay = layer_from(41, t, PER_CH56);
            gt = t + 16 * PER_CH12 + 8 * PER_CH3 + 8 * PER_CH4 + 8 * PER_CH56 + 640 +
                 hole_flat_shift(kind, t, lay - 40, PER_CH56, NEAR_CH56_LOW, NEAR_CH56, 24);
         end
         default: ;
      endcase
      if (lay <= 46) begin
         m = lay & 7;
         if (m == 3 || m == 4)
            sk = 1;
         else if (m == 5 || m == 6)
            sk = -1;
      end
      r.layer = lay[5:0];
      r.global_tube = gt[13:0];
      r.skew = sk[1:0];
      r.hit = hit;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Tube numbers cluster on layer boundaries and hole thresholds, with a share
   // spread over the whole field.
   function automatic logic [11:0] pick_tube(input logic [2:0] chamber);
      int per;
      int low;
      int near;
      int v;
      case (chamber)
         CHAMBER_3: begin
            per = PER_CH3; low = NEAR_CH3; near = NEAR_CH3;
         end
         CHAMBER_4: begin
            per = PER_CH4; low = NEAR_CH4_LOW; near = NEAR_CH4;
         end
         CHAMBER_5, CHAMBER_6: begin
            per = PER_CH56; low = NEAR_CH56_LOW; near = NEAR_CH56;
         end
         default: begin
            per = PER_CH12; low = NEAR_CH12; near = NEAR_CH12;
         end
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom_range(4095);
         4, 5, 6: v = $urandom_range(4095 / per) * per + $urandom_range(6) - 3;
         7: v = low + $urandom_range(4) - 2;
         default: v = $urandom_range(1, 3) * per + ($urandom_range(1) ? near : -near) +
                      $urandom_range(4) - 2;
      endcase
      if (v < 0)
         v = 0;
      if (v > 4095)
         v = 4095;
      return v[11:0];
   endfunction

   task automatic send_hit(input logic [2:0] chamber, input logic [11:0] tube,
                           input logic [1:0] quarter, input logic [1:0] kind);
      logic [18:0] hit;
      hit = {kind, quarter, tube, chamber};
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(IN_DATA_W - 19){1'b0}}, hit};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_maps.push_back(map_hit(hit));
   endtask

   task automatic send_random_hit();
      logic [2:0] chamber;
      int         c;
      c = $urandom_range(13);
      if (c >= 12)
         chamber = (c == 12) ? 3'd0 : 3'd7;
      else
         chamber = 3'(c / 2 + 1);
      send_hit(chamber, pick_tube(chamber), 2'($urandom_range(3)), 2'($urandom_range(3)));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_maps.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_corner_hits();
      send_idle_pct = 20;
      stall_pct <= 20;
      send_hit(3'd0, 12'd123, 2'd1, KIND_UP);
      send_hit(3'd7, 12'd4095, 2'd3, KIND_DOWN);
      send_hit(CHAMBER_1, 12'd0, 2'd0, KIND_FULL);
      send_hit(CHAMBER_1, 12'd61, 2'd0, KIND_FULL);
      send_hit(CHAMBER_1, 12'd71, 2'd0, KIND_FULL);
      send_hit(CHAMBER_1, 12'd72, 2'd0, KIND_FULL);
      send_hit(CHAMBER_1, 12'd132, 2'd3, KIND_ALT);
      send_hit(CHAMBER_1, 12'd133, 2'd2, KIND_UP);
      send_hit(CHAMBER_2, 12'd4095, 2'd0, KIND_DOWN);
      send_hit(CHAMBER_2, 12'd2048, 2'd1, KIND_FULL);
      send_hit(CHAMBER_3, 12'd0, 2'd0, KIND_UP);
      send_hit(CHAMBER_3, 12'd81, 2'd0, KIND_FULL);
      send_hit(CHAMBER_3, 12'd95, 2'd0, KIND_FULL);
      send_hit(CHAMBER_3, 12'd176, 2'd1, KIND_DOWN);
      send_hit(CHAMBER_3, 12'd352, 2'd3, KIND_ALT);
      // Past the fourth layer pair only the chamber and hole shifts remain.
      send_hit(CHAMBER_3, 12'd4095, 2'd3, KIND_FULL);
      send_hit(CHAMBER_4, 12'd97, 2'd0, KIND_FULL);
      send_hit(CHAMBER_4, 12'd105, 2'd0, KIND_FULL);
      send_hit(CHAMBER_4, 12'd311, 2'd2, KIND_FULL);
      send_hit(CHAMBER_4, 12'd4095, 2'd3, KIND_UP);
      send_hit(CHAMBER_5, 12'd177, 2'd0, KIND_FULL);
      send_hit(CHAMBER_5, 12'd194, 2'd0, KIND_FULL);
      send_hit(CHAMBER_5, 12'd389, 2'd1, KIND_DOWN);
      send_hit(CHAMBER_6, 12'd1, 2'd0, KIND_UP);
      send_hit(CHAMBER_6, 12'd4095, 2'd2, KIND_ALT);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall);
      send_idle_pct = idle_pct;
      stall_pct <= stall;
      repeat (count)
         send_random_hit();
      wait_for_results();
   endtask

   // The output side holds off long enough for the block to fill and stall its input.
   task automatic test_output_holdoff();
      send_idle_pct = 0;
      stall_pct <= 0;
      holdoff_ticket <= holdoff_ticket + 1;
      repeat (120)
         send_random_hit();
      wait_for_results();
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string text);
      if (mismatch_count < MAX_PRINTED)
         $display("MISMATCH at cycle %0d: %s", cycle_count, text);
      mismatch_count++;
   endtask

   function automatic string hit_text(input logic [18:0] hit);
      return $sformatf("chamber %0d tube %0d quarter %0d kind %0d",
                       hit[2:0], hit[14:3], hit[16:15], hit[18:17]);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_maps.size() == 0) begin
            report_mismatch($sformatf("result %h with no hit outstanding", rsp_tdata));
         end else begin
            want = pending_maps.pop_front();
            if (rsp_tdata[5:0] !== want.layer)
               report_mismatch($sformatf("layer %0d, expected %0d (%s)", rsp_tdata[5:0],
                                         want.layer, hit_text(want.hit)));
            if (rsp_tdata[19:6] !== want.global_tube)
               report_mismatch($sformatf("global_tube %0d, expected %0d (%s)",
                                         rsp_tdata[19:6], want.global_tube,
                                         hit_text(want.hit)));
            if (rsp_tdata[21:20] !== want.skew)
               report_mismatch($sformatf("skew %0d, expected %0d (%s)",
                                         $signed(rsp_tdata[21:20]), $signed(want.skew),
                                         hit_text(want.hit)));
         end
      end
   end

   // Output-side ready: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (holdoff_ticket != holdoff_seen) begin
         holdoff_seen <= holdoff_ticket;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("straw_tube_channel_mapper regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_hits();
      test_random_traffic(400, 0, 0);
      test_random_traffic(400, 56, 0);
      test_random_traffic(400, 0, 56);
      test_random_traffic(400, 23, 23);
      test_output_holdoff();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_maps.size() == 0)
         $display("straw_tube_channel_mapper regression: pass");
      else
         $display("straw_tube_channel_mapper regression: fail");
      $finish;
   end

endmodule
